// ----- src/sm4_pkg.sv -----
`timescale 1ns / 1ps

package sm4_pkg;

    localparam int ROUNDS   = 32;
    localparam int RK_AW    = $clog2(ROUNDS);
    localparam int CNT_W    = $clog2(ROUNDS + 1);

    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;

    // configuration register indexes
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } sm4_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } sm4_out_t;

    // control from the sequencer to the word chain
    typedef struct packed {
        logic       load;
        logic       shift;
        logic       key_mode;
    } sm4_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // CK word i: byte j = (4*i + j) * 7 mod 256
    function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
        logic [31:0] w;
        logic [7:0]  b;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            b = 8'(({6'd0, i} * 8'd4 + 8'(j)) * 8'd7);
            w = {w[23:0], b};
        end
        return w;
    endfunction

endpackage

// ----- src/sm4_tunit.sv -----
`timescale 1ns / 1ps

// Shared round function: S-box on four bytes, then data or key linear mix
module sm4_tunit
    import sm4_pkg::*;
(
    input  logic [31:0] a,
    input  logic        key_mode,
    output logic [31:0] t
);

    logic [31:0] b;

    // byte-wise substitution
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            b[8*k +: 8] = SBOX[a[8*k +: 8]];
        end
    end

    // linear mix L or L'
    always_comb begin
        if (key_mode) begin
            t = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
        end else begin
            t = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                  ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
        end
    end

endmodule

// ----- src/sm4_word_cell.sv -----
`timescale 1ns / 1ps

// One 32-bit word of the state chain; takes its neighbor's word each round
module sm4_word_cell
    import sm4_pkg::*;
(
    input  logic        aclk,
    input  sm4_ctl_t    ctl,
    input  logic [31:0] load_word,
    input  logic [31:0] shift_in,
    output logic [31:0] word
);

    logic [31:0] word_reg;
    logic [31:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (ctl.load) begin
            word_next = load_word;
        end else if (ctl.shift) begin
            word_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- src/sm4_ram.sv -----
`timescale 1ns / 1ps

// Generic single-port-write, registered-read RAM
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/sm4_block_cipher_core.sv -----
`timescale 1ns / 1ps

// SM4 block cipher core, 128-bit key and block. A key write (index 0 = key
// high, 1 = key low) starts a key schedule that writes the 32 round keys
// into a small RAM; writing the block before any key write runs the
// schedule on the all-zero key first. A block passes from accept through a
// pending step, a load and round-key read step, the 32 rounds and an output
// capture that waits while the output register is full, one round per cycle
// through a single S-box/linear-mix unit feeding a chain of four 32-bit word
// cells. One block is in flight at a time; the result sits in an output
// register and the next block is accepted while it waits.
module sm4_block_cipher_core
    import sm4_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sm4_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output sm4_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_KEY, ST_PRE, ST_RUN} state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               keys_ready_reg;
    logic               pend_reg;
    logic               op_reg;
    sm4_in_t            blk_reg;
    logic [63:0]        key_high_reg;
    logic [63:0]        key_low_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    sm4_out_t           m_data_reg;

    sm4_ctl_t           ctl;
    logic [31:0]        w [4];
    logic [31:0]        load_w [4];
    logic [31:0]        t_in;
    logic [31:0]        t_out;
    logic [31:0]        nx;
    logic [31:0]        rk;
    logic [RK_AW-1:0]   rd_addr;
    logic [RK_AW-1:0]   rnd;
    logic               s_fire;
    logic               cfg_fire;
    logic               out_free;
    logic               run_done;
    logic [63:0]        key_high_eff;
    logic [63:0]        key_low_eff;

    assign rnd      = cnt_reg[RK_AW-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !pend_reg && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE) && !pend_reg;
    assign s_fire   = s_valid && s_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign run_done = (state_reg == ST_RUN) && (cnt_reg == CNT_W'(ROUNDS));

    // key as it stands after this cycle's write, for seeding the schedule
    assign key_high_eff = (cfg_fire && cfg_index == CFG_KEY_HIGH) ? cfg_data : key_high_reg;
    assign key_low_eff  = (cfg_fire && cfg_index == CFG_KEY_LOW)  ? cfg_data : key_low_reg;

    // chain load values: key schedule seeds or data block
    always_comb begin
        if (state_reg == ST_IDLE && !s_fire) begin
            load_w[0] = key_high_eff[63:32] ^ FK0;
            load_w[1] = key_high_eff[31:0]  ^ FK1;
            load_w[2] = key_low_eff[63:32]  ^ FK2;
            load_w[3] = key_low_eff[31:0]   ^ FK3;
        end else begin
            load_w[0] = blk_reg.block_high[63:32];
            load_w[1] = blk_reg.block_high[31:0];
            load_w[2] = blk_reg.block_low[63:32];
            load_w[3] = blk_reg.block_low[31:0];
        end
    end

    always_comb begin
        ctl.key_mode = (state_reg == ST_KEY);
        ctl.load     = (state_reg == ST_PRE) ||
                       (state_reg == ST_IDLE && (cfg_fire || (pend_reg && !keys_ready_reg)));
        ctl.shift    = (state_reg == ST_KEY && cnt_reg != CNT_W'(ROUNDS))
                       || (state_reg == ST_RUN && cnt_reg != CNT_W'(ROUNDS));
    end

    // round input: ck for key rounds, round key for data rounds
    assign t_in = w[1] ^ w[2] ^ w[3] ^ (ctl.key_mode ? ck_word(rnd) : rk);
    assign nx   = w[0] ^ t_out;

    sm4_tunit u_tunit (
        .a        (t_in),
        .key_mode (ctl.key_mode),
        .t        (t_out)
    );

    // word chain: each cell takes its right neighbor, the last takes the new word
    for (genvar g = 0; g < 4; g++) begin : g_cell
        sm4_word_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .load_word (load_w[g]),
            .shift_in  ((g == 3) ? nx : w[(g + 1) % 4]),
            .word      (w[g])
        );
    end

    // round key for the next round is read while the current round runs
    always_comb begin
        if (state_reg == ST_RUN) begin
            rd_addr = op_reg ? RK_AW'(ROUNDS - 2) - rnd : rnd + RK_AW'(1);
        end else begin
            rd_addr = op_reg ? RK_AW'(ROUNDS - 1) : '0;
        end
    end

    sm4_ram #(.WIDTH(32), .DEPTH(ROUNDS)) u_rk_ram (
        .aclk    (aclk),
        .wr_en   (ctl.key_mode && ctl.shift),
        .wr_addr (rnd),
        .wr_data (nx),
        .rd_addr (rd_addr),
        .rd_data (rk)
    );

    // output valid: cleared on accept, set when a finished block is captured
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (run_done && out_free) begin
            m_valid_next = 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            keys_ready_reg <= 1'b0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            key_high_reg   <= '0;
            key_low_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (cfg_fire) begin
                        if (cfg_index == CFG_KEY_HIGH) begin
                            key_high_reg <= cfg_data;
                        end else begin
                            key_low_reg <= cfg_data;
                        end
                        state_reg <= ST_KEY;
                    end else if (s_fire) begin
                        blk_reg  <= s_data;
                        op_reg   <= s_data.op;
                        pend_reg <= 1'b1;
                    end else if (pend_reg) begin
                        state_reg <= keys_ready_reg ? ST_PRE : ST_KEY;
                    end
                end
                ST_KEY: begin
                    if (cnt_reg == CNT_W'(ROUNDS)) begin
                        keys_ready_reg <= 1'b1;
                        cnt_reg        <= '0;
                        state_reg      <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_PRE: begin
                    pend_reg  <= 1'b0;
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    if (cnt_reg == CNT_W'(ROUNDS)) begin
                        if (out_free) begin
                            m_data_reg  <= '{result_high: {w[3], w[2]},
                                             result_low:  {w[1], w[0]}};
                            cnt_reg     <= '0;
                            state_reg   <= ST_IDLE;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // hold the chain while finished rounds wait on the output register
    // (shift stops when the round count reaches ROUNDS)

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN || state_reg == ST_KEY) |-> !s_ready && !cfg_ready)
        else $error("beat accepted while busy");

    a_keys_before_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PRE |-> keys_ready_reg)
        else $error("block started without round keys");

endmodule
